// File: sv/tihr_pkg.sv
// Shared types and constants for the time-indexed history ring.
// Used by tihr_div and time_indexed_history_ring_core; depends on nothing.
`default_nettype none
package tihr_pkg;

  // Fixed field widths.
  localparam int ROW_W   = 64;
  localparam int SEC_W   = 40;
  localparam int MSIN_W  = 47;
  localparam int STEP_W  = 32;
  localparam int MSOUT_W = 48;
  localparam int TICK_W  = 12;
  localparam int CNT_W   = 48;

  // Internal arithmetic widths.
  localparam int NUM_W  = 52;   // divider dividend
  localparam int DEN_W  = 32;   // divider divisor
  localparam int SW     = 52;   // signed tick index arithmetic
  localparam int DMS_W  = 22;   // tick length in milliseconds
  localparam int SECS_W = 62;   // row time in seconds

  localparam int MAX_RESULTS = 64;
  localparam int NRES_W      = 7;

  localparam logic [9:0]         MS_PER_S  = 10'd1000;
  localparam logic [MSOUT_W-1:0] MS_SAT    = {MSOUT_W{1'b1}};
  // Largest second count whose millisecond value still fits in 48 bits.
  localparam logic [SECS_W-1:0]  SECS_SAT  = SECS_W'(64'd281474976710);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                command;
    logic [ROW_W-1:0]    row_value;
    logic [SEC_W-1:0]    now_seconds;
    logic [MSIN_W-1:0]   from_ms;
    logic [MSIN_W-1:0]   to_ms;
    logic [STEP_W-1:0]   step_ms;
  } in_item_t;

  typedef struct packed {
    logic [MSOUT_W-1:0]  row_time_ms;
    logic [ROW_W-1:0]    row_data;
    logic                found;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/tihr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tihr_pkg for widths and the request and response structs.
`default_nettype none
module tihr_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tihr_pkg::div_req_t req,
  output tihr_pkg::div_rsp_t     rsp
);
  import tihr_pkg::*;

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [5:0]       cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= 6'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.go) begin
      quo <= req.num;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(trial - {1'b0, req.den}) : trial[DEN_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// File: sv/time_indexed_history_ring_core.sv
// Time-indexed history ring: push rows one per tick, query them by time range.
// A push is taken while the core is idle. A query runs up to four divisions (stride,
// start, end, stride rounding) on one shared restoring divider, and each division
// holds the sequencer until the divider is done. Each row of a query then passes
// through an address and memory read step and then an output register step, up to
// 64 rows, and a stalled receiver holds it. An empty query returns one marker, both
// on an empty ring and when the range misses.
// tick_seconds is written through cfg_we/cfg_wdata; a value of zero acts as one second.
`default_nettype none
module time_indexed_history_ring_core #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [tihr_pkg::TICK_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tihr_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tihr_pkg::out_item_t              out_data
);
  import tihr_pkg::*;

  localparam int HW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_STRIDE = 12'b000000000010,
    S_PREP   = 12'b000000000100,
    S_FROM   = 12'b000000001000,
    S_TO     = 12'b000000010000,
    S_CLAMP  = 12'b000000100000,
    S_CHECK  = 12'b000001000000,
    S_ROUND  = 12'b000010000000,
    S_SECS   = 12'b000100000000,
    S_ADDR   = 12'b001000000000,
    S_READ   = 12'b010000000000,
    S_EMPTY  = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration and ring state.
  logic [TICK_W-1:0] tick_seconds;
  logic [HW-1:0]     head_slot;
  logic [CW-1:0]     held_count;
  logic [CNT_W-1:0]  pushes_total;
  logic [SEC_W-1:0]  epoch_seconds;
  logic [ROW_W-1:0]  ring_mem [RING_DEPTH];
  logic [ROW_W-1:0]  rd_data;
  logic [HW-1:0]     rd_addr;

  // Query working registers.
  logic [MSIN_W-1:0]    from_q;
  logic [MSIN_W-1:0]    to_q;
  logic [STEP_W-1:0]    stride;
  logic signed [SW-1:0] t0ms;
  logic signed [SW-1:0] diff_from;
  logic signed [SW-1:0] diff_to;
  logic signed [SW-1:0] start_idx;
  logic signed [SW-1:0] end_idx;
  logic signed [SW-1:0] next_idx;
  logic                 rounded;
  logic [SECS_W-1:0]    secs;
  logic [43:0]          stride_secs;
  logic [NRES_W-1:0]    n_out;
  logic                 row_last;
  logic [MSOUT_W-1:0]   row_ms;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // Derived values.
  logic [TICK_W-1:0]    tick_eff;
  logic [DMS_W-1:0]     dms;
  logic                 out_free;
  logic                 push_xfer;
  logic                 query_xfer;
  logic signed [SW-1:0] oldest;
  logic signed [SW-1:0] newest;
  logic signed [SW-1:0] q_signed;
  logic signed [SW-1:0] q_up;
  logic                 rem_nz;
  logic [CW-1:0]        age;
  logic [CW:0]          slot_sum;
  logic [HW-1:0]        slot;
  logic signed [SW-1:0] idx_step;
  logic                 div_go_next;
  logic                 load_out;

  assign tick_eff   = (tick_seconds == '0) ? TICK_W'(1) : tick_seconds;
  assign dms        = DMS_W'(tick_eff) * DMS_W'(MS_PER_S);
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);
  assign push_xfer  = in_valid && in_ready && (in_data.command == CMD_PUSH);
  assign query_xfer = in_valid && in_ready && (in_data.command == CMD_QUERY);
  assign oldest     = $signed(SW'(pushes_total)) - $signed(SW'(held_count));
  assign newest     = $signed(SW'(pushes_total)) - $signed(SW'(1));
  assign rem_nz     = (div_rsp.rem != '0);
  assign q_signed   = $signed(div_rsp.quo);
  assign q_up       = q_signed + $signed(SW'(rem_nz));
  assign idx_step   = $signed(SW'(stride));

  // A division starts on the cycle after one of these steps.
  assign div_go_next = query_xfer || (state == S_PREP) ||
                       ((state == S_FROM) && div_rsp.done) ||
                       ((state == S_CHECK) && (start_idx <= end_idx) &&
                        (stride > STEP_W'(1)) && !rounded);

  // A result is loaded whenever one is ready and the output register is free.
  assign load_out = ((state == S_READ) || (state == S_EMPTY)) && out_free;

  // Ring position of the row for the current tick index, counted back from the head.
  assign age      = CW'(newest - start_idx);
  assign slot_sum = (CW+1)'(head_slot) + (CW+1)'(RING_DEPTH - 1) - (CW+1)'(age);
  assign slot     = (slot_sum >= (CW+1)'(RING_DEPTH)) ?
                    HW'(slot_sum - (CW+1)'(RING_DEPTH)) : HW'(slot_sum);

  tihr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_seconds <= TICK_W'(1);
    end else if (cfg_we) begin
      tick_seconds <= cfg_wdata;
    end
  end

  // Ring bookkeeping on a push transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot     <= '0;
      held_count    <= '0;
      pushes_total  <= '0;
      epoch_seconds <= '0;
    end else if (push_xfer) begin
      if (pushes_total == '0) begin
        epoch_seconds <= in_data.now_seconds;
      end
      head_slot <= (head_slot == HW'(RING_DEPTH - 1)) ? '0 : head_slot + HW'(1);
      if (held_count < CW'(RING_DEPTH)) begin
        held_count <= held_count + CW'(1);
      end
      if (pushes_total != {CNT_W{1'b1}}) begin
        pushes_total <= pushes_total + CNT_W'(1);
      end
    end
  end

  // Row memory: written on a push, read with a registered port.
  always_ff @(posedge clk) begin
    if (push_xfer) begin
      ring_mem[head_slot] <= in_data.row_value;
    end
    if (state == S_ADDR) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

  assign rd_addr = slot;

  // Query sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      div_req.go <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      div_req.go <= div_go_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (query_xfer) begin
            from_q      <= in_data.from_ms;
            to_q        <= in_data.to_ms;
            t0ms        <= $signed(SW'(epoch_seconds * 50'(MS_PER_S)));
            rounded     <= 1'b0;
            div_req.num <= NUM_W'(in_data.step_ms);
            div_req.den <= DEN_W'(dms);
            state       <= S_STRIDE;
          end
        end
        S_STRIDE: begin
          if (div_rsp.done) begin
            stride <= (div_rsp.quo > NUM_W'(1)) ? STEP_W'(div_rsp.quo) : STEP_W'(1);
            state  <= (held_count == '0) ? S_EMPTY : S_PREP;
          end
        end
        S_PREP: begin
          diff_from   <= $signed(SW'(from_q)) - t0ms;
          diff_to     <= $signed(SW'(to_q)) - t0ms;
          div_req.num <= NUM_W'((($signed(SW'(from_q)) - t0ms) < 0) ?
                                 (t0ms - $signed(SW'(from_q))) :
                                 ($signed(SW'(from_q)) - t0ms));
          state       <= S_FROM;
        end
        S_FROM: begin
          if (div_rsp.done) begin
            // Ceiling of a signed quotient from the magnitude division.
            start_idx   <= (diff_from < 0) ? -q_signed : q_up;
            div_req.num <= NUM_W'((diff_to < 0) ? -diff_to : diff_to);
            state       <= S_TO;
          end
        end
        S_TO: begin
          if (div_rsp.done) begin
            // Floor of a signed quotient from the magnitude division.
            end_idx <= (diff_to < 0) ? -q_up : q_signed;
            state   <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (start_idx < oldest) begin
            start_idx <= oldest;
          end
          if (end_idx > newest) begin
            end_idx <= newest;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (start_idx > end_idx) begin
            state <= S_EMPTY;
          end else if ((stride > STEP_W'(1)) && !rounded) begin
            div_req.num <= NUM_W'(start_idx);
            div_req.den <= DEN_W'(stride);
            state       <= S_ROUND;
          end else begin
            state <= S_SECS;
          end
        end
        S_ROUND: begin
          if (div_rsp.done) begin
            // Round the start up to the next multiple of the stride.
            if (rem_nz) begin
              start_idx <= start_idx + $signed(SW'(stride - div_rsp.rem));
            end
            rounded <= 1'b1;
            state   <= S_CHECK;
          end
        end
        S_SECS: begin
          secs        <= SECS_W'(epoch_seconds) +
                         SECS_W'(60'(start_idx[CNT_W-1:0]) * 60'(tick_eff));
          stride_secs <= 44'(stride) * 44'(tick_eff);
          n_out       <= '0;
          state       <= S_ADDR;
        end
        S_ADDR: begin
          next_idx <= start_idx + idx_step;
          row_last <= ((start_idx + idx_step) > end_idx) ||
                      (n_out == NRES_W'(MAX_RESULTS - 1));
          row_ms   <= (secs > SECS_SAT) ? MS_SAT :
                      MSOUT_W'(secs[38:0] * 49'(MS_PER_S));
          state    <= S_READ;
        end
        S_READ: begin
          if (out_free) begin
            out_data.row_time_ms <= row_ms;
            out_data.row_data    <= rd_data;
            out_data.found       <= 1'b1;
            out_data.last        <= row_last;
            start_idx            <= next_idx;
            secs                 <= secs + SECS_W'(stride_secs);
            n_out                <= n_out + NRES_W'(1);
            state                <= row_last ? S_IDLE : S_ADDR;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_data.row_time_ms <= '0;
            out_data.row_data    <= '0;
            out_data.found       <= 1'b0;
            out_data.last        <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The held count never exceeds the ring depth.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(RING_DEPTH))
    else $error("held count above ring depth");

  // The head pointer stays inside the ring.
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head_slot <= HW'(RING_DEPTH - 1))
    else $error("head slot outside ring");

  // A division result arrives only while the sequencer waits for one.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_STRIDE || state == S_FROM ||
                      state == S_TO || state == S_ROUND))
    else $error("divider finished outside a divide step");

  // A new result is loaded only into a free output register.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_EMPTY) && out_valid && !out_ready |=>
      $stable(out_data))
    else $error("output overwritten while stalled");

endmodule
`default_nettype wire
